@@ rtl/lome_pkg.sv @@
// ---------------------------------------------------------------------------
// lome_pkg
// Shared types and codes for the order matching engine.
// ---------------------------------------------------------------------------
package lome_pkg;

  typedef enum logic [2:0] {
    KIND_FILL     = 3'd0,
    KIND_RESTED   = 3'd1,
    KIND_DISCARD  = 3'd2,
    KIND_FILLED   = 3'd3,
    KIND_REJECTED = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MATCH,
    ST_DROP,
    ST_INS,
    ST_STATUS
  } state_e;

endpackage

@@ rtl/limit_order_matching_engine.sv @@
// ---------------------------------------------------------------------------
// limit_order_matching_engine
// Price-time priority bid/ask book with a sequential matcher.
// ---------------------------------------------------------------------------
// Usage: drive an order item on the *_i ports with start_i high while busy_o
// is low; the item is taken at that edge and busy_o rises in the next cycle.
// Each result appears for one cycle with valid_o high; the receiver cannot
// stall, so no result is ever held. A run gives zero or more fills and ends
// with one status result carrying last_o.
// Sequence: after the accepting edge each head is read and then matched; a
// fill that empties the head is followed by a drop walk that moves every
// later entry of the opposite book down by one. A partial fill or a price
// that no longer crosses goes straight to status; a spent order or a dry
// book passes through the read state once more first. The status strobe
// shows in the cycle after the status state. Resting adds an insert walk
// behind the status that moves up the entries ranking after the new price.
// Flow: the next item is taken in the first idle cycle, so a new order waits
// out the whole run, the worst case being a sweep of a full book followed by
// resting beside BOOK_DEPTH - 1 own orders. One entry is moved per cycle in
// the drop and insert walks.
// Reset clears both counts (books empty); entry storage is not cleared.
// ---------------------------------------------------------------------------
module limit_order_matching_engine #(
  parameter int BOOK_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] order_ref_i,
  input  logic        is_sell_i,
  input  logic        is_market_i,
  input  logic [31:0] limit_price_i,
  input  logic [31:0] order_qty_i,
  output logic        valid_o,
  output logic [2:0]  kind_o,
  output logic [31:0] taker_ref_o,
  output logic [31:0] maker_ref_o,
  output logic [31:0] trade_qty_o,
  output logic [31:0] trade_price_o,
  output logic        last_o
);
  import lome_pkg::*;

  localparam int AW = $clog2(BOOK_DEPTH);
  localparam int CW = $clog2(BOOK_DEPTH + 1);

  // Books: index 0 = ask, 1 = bid
  logic [95:0] book_q [2][BOOK_DEPTH];
  logic [CW-1:0] cnt_q [2];

  state_e st_q, st_d;
  logic [31:0] ref_q, px_q, left_q;
  logic sell_q, mkt_q;
  logic [CW-1:0] pos_q;     // walk index
  logic [95:0] head_q;      // registered read of one entry
  kind_e       status_kind;

  // Opposite book is ask for buy (0), bid for sell (1); own book the reverse
  logic opp, own;
  assign opp = sell_q;
  assign own = ~sell_q;

  logic [31:0] hp, hl, ho;
  assign hp = head_q[95:64];
  assign hl = head_q[63:32];
  assign ho = head_q[31:0];

  logic crosses, take_all;
  assign crosses  = mkt_q || (sell_q ? (px_q <= hp) : (px_q >= hp));
  assign take_all = left_q >= hl;

  // Insert walk: move entry pos-1 up while it ranks after the new price
  logic [95:0] prev_e;
  logic        move_up;
  assign prev_e  = book_q[own][AW'(pos_q - CW'(1))];
  assign move_up = (pos_q != '0) &&
                   (sell_q ? (prev_e[95:64] > px_q) : (prev_e[95:64] < px_q));

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE:  if (start_i) st_d = ST_READ;
      ST_READ: begin
        if (left_q == '0 || cnt_q[opp] == '0) st_d = ST_STATUS;
        else st_d = ST_MATCH;
      end
      ST_MATCH: begin
        if (!crosses) st_d = ST_STATUS;
        else if (take_all) st_d = ST_DROP;
        else st_d = ST_STATUS;
      end
      ST_DROP:  if (pos_q + CW'(1) >= cnt_q[opp]) st_d = ST_READ;
      ST_INS:   if (!move_up) st_d = ST_IDLE;
      ST_STATUS: begin
        if (status_kind == KIND_RESTED) st_d = ST_INS;
        else st_d = ST_IDLE;
      end
      default:  st_d = ST_IDLE;
    endcase
  end

  logic status_now;
  assign status_now = (st_q == ST_STATUS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      cnt_q[0] <= '0;
      cnt_q[1] <= '0;
      valid_o <= 1'b0;
      last_o  <= 1'b0;
    end else begin
      st_q    <= st_d;
      valid_o <= 1'b0;
      last_o  <= 1'b0;
      case (st_q)
        ST_IDLE: begin
          if (start_i) begin
            ref_q  <= order_ref_i;
            sell_q <= is_sell_i;
            mkt_q  <= is_market_i;
            px_q   <= limit_price_i;
            left_q <= order_qty_i;
          end
        end
        ST_READ: begin
          head_q <= book_q[opp][0];
          pos_q  <= '0;
        end
        ST_MATCH: begin
          if (crosses) begin
            valid_o       <= 1'b1;
            kind_o        <= KIND_FILL;
            taker_ref_o   <= ref_q;
            maker_ref_o   <= ho;
            trade_price_o <= hp;
            if (take_all) begin
              trade_qty_o <= hl;
              left_q      <= left_q - hl;
              pos_q       <= '0;
            end else begin
              trade_qty_o <= left_q;
              left_q      <= '0;
              book_q[opp][0][63:32] <= hl - left_q;
            end
          end
        end
        ST_DROP: begin
          if (pos_q + CW'(1) < cnt_q[opp]) begin
            book_q[opp][AW'(pos_q)] <= book_q[opp][AW'(pos_q + CW'(1))];
            pos_q <= pos_q + CW'(1);
          end else begin
            cnt_q[opp] <= cnt_q[opp] - CW'(1);
          end
        end
        ST_STATUS: begin
          valid_o       <= 1'b1;
          last_o        <= 1'b1;
          kind_o        <= status_kind;
          taker_ref_o   <= ref_q;
          maker_ref_o   <= '0;
          trade_price_o <= '0;
          trade_qty_o   <= left_q;
          pos_q         <= cnt_q[own];
        end
        ST_INS: begin
          if (move_up) begin
            book_q[own][AW'(pos_q)] <= prev_e;
            pos_q <= pos_q - CW'(1);
          end else begin
            book_q[own][AW'(pos_q)] <= {px_q, left_q, ref_q};
            cnt_q[own] <= cnt_q[own] + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Status code chosen from the leftover, the market flag and the own book's fill
  always_comb begin
    if (left_q == '0) status_kind = KIND_FILLED;
    else if (mkt_q) status_kind = KIND_DISCARD;
    else if (cnt_q[own] >= CW'(BOOK_DEPTH)) status_kind = KIND_REJECTED;
    else status_kind = KIND_RESTED;
  end

  assign busy_o = (st_q != ST_IDLE) || status_now;
endmodule

@@ rtl/lome_checker.sv @@
// ---------------------------------------------------------------------------
// lome_checker
// Port-level checks on the matching engine.
// ---------------------------------------------------------------------------
module lome_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        valid_o,
  input logic        last_o,
  input logic [2:0]  kind_o,
  input logic [31:0] maker_ref_o
);
  import lome_pkg::*;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("no busy after accept");
  a_last_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o) |-> (kind_o != KIND_FILL)) else $error("fill marked last");
  a_fill_nlast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |-> (kind_o == KIND_FILL)) else $error("status not last");
  a_status_maker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o) |-> (maker_ref_o == '0)) else $error("maker on status");
endmodule

bind limit_order_matching_engine lome_checker u_chk (
  .clk_i, .rst_ni, .start_i, .busy_o, .valid_o, .last_o, .kind_o, .maker_ref_o
);

@@ verif/tb.sv @@
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the order matching engine: orders go in through the
// start/busy handshake, a local copy of both books predicts the fills and the
// status of each item, and a monitor checks every strobed result in order.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lome_pkg::*;

  localparam int DEPTH = 32;
  localparam int STALL_LIMIT = 20000; // watchdog limit on cycles without progress

  typedef struct packed {
    kind_e       kind;
    logic [31:0] taker;
    logic [31:0] maker;
    logic [31:0] qty;
    logic [31:0] price;
    logic        last;
  } trade_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [31:0] order_ref_i = '0;
  logic        is_sell_i = 1'b0;
  logic        is_market_i = 1'b0;
  logic [31:0] limit_price_i = '0;
  logic [31:0] order_qty_i = '0;
  logic        busy_o, valid_o, last_o;
  logic [2:0]  kind_o;
  logic [31:0] taker_ref_o, maker_ref_o, trade_qty_o, trade_price_o;

  limit_order_matching_engine #(.BOOK_DEPTH(DEPTH)) u_top (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predicted books; entry 0 is the best order
  logic [31:0] ask_px[DEPTH], ask_qty[DEPTH], ask_id[DEPTH];
  logic [31:0] bid_px[DEPTH], bid_qty[DEPTH], bid_id[DEPTH];
  int ask_n = 0, bid_n = 0;

  trade_t expected_trades[$];
  int     errors = 0;
  int     gap_pct = 0;   // sender idle chance in percent
  int     quiet = 0;
  logic [31:0] next_ref = 32'd1;

  // queue one expected result at the back
  function automatic void add_expect(input trade_t e);
    expected_trades.insert(expected_trades.size(), e);
  endfunction

  // Match one order against the opposite book, then report filled, rest, discard or reject.
  task automatic book_order(input logic [31:0] oref, input logic sell, input logic mkt,
                            input logic [31:0] px, input logic [31:0] qty);
    logic [31:0] left, t, hp, hq, hid;
    bit crosses;
    int pos, i, fills;
    left = qty;
    fills = 0;
    while (left != 0 && (sell ? bid_n : ask_n) > 0 && fills < DEPTH) begin
      hp = sell ? bid_px[0] : ask_px[0];
      hq = sell ? bid_qty[0] : ask_qty[0];
      hid = sell ? bid_id[0] : ask_id[0];
      crosses = mkt || (sell ? px <= hp : px >= hp);
      if (!crosses) break;
      t = (left < hq) ? left : hq;
      add_expect(trade_t'{KIND_FILL, oref, hid, t, hp, 1'b0});
      fills++;
      left -= t;
      if (sell) bid_qty[0] -= t; else ask_qty[0] -= t;
      if (hq == t) begin
        // head exhausted: shift the book up by one
        if (sell) begin
          for (i = 1; i < bid_n; i++) begin
            bid_px[i-1] = bid_px[i]; bid_qty[i-1] = bid_qty[i]; bid_id[i-1] = bid_id[i];
          end
          bid_n--;
        end else begin
          for (i = 1; i < ask_n; i++) begin
            ask_px[i-1] = ask_px[i]; ask_qty[i-1] = ask_qty[i]; ask_id[i-1] = ask_id[i];
          end
          ask_n--;
        end
      end
    end
    if (left == 0)
      add_expect(trade_t'{KIND_FILLED, oref, 32'd0, 32'd0, 32'd0, 1'b1});
    else if (mkt)
      add_expect(trade_t'{KIND_DISCARD, oref, 32'd0, left, 32'd0, 1'b1});
    else if ((sell ? ask_n : bid_n) >= DEPTH)
      add_expect(trade_t'{KIND_REJECTED, oref, 32'd0, left, 32'd0, 1'b1});
    else begin
      // insert behind equal prices to keep arrival order
      if (sell) begin
        pos = ask_n;
        while (pos > 0 && ask_px[pos-1] > px) begin
          ask_px[pos] = ask_px[pos-1]; ask_qty[pos] = ask_qty[pos-1]; ask_id[pos] = ask_id[pos-1];
          pos--;
        end
        ask_px[pos] = px; ask_qty[pos] = left; ask_id[pos] = oref; ask_n++;
      end else begin
        pos = bid_n;
        while (pos > 0 && bid_px[pos-1] < px) begin
          bid_px[pos] = bid_px[pos-1]; bid_qty[pos] = bid_qty[pos-1]; bid_id[pos] = bid_id[pos-1];
          pos--;
        end
        bid_px[pos] = px; bid_qty[pos] = left; bid_id[pos] = oref; bid_n++;
      end
      add_expect(trade_t'{KIND_RESTED, oref, 32'd0, left, 32'd0, 1'b1});
    end
  endtask

  // Send one item: optional idle gap, then hold start until the block takes it.
  task automatic send_order(input logic [31:0] oref, input logic sell, input logic mkt,
                            input logic [31:0] px, input logic [31:0] qty);
    while ($urandom_range(99) < gap_pct) @(posedge clk_i);
    start_i <= 1'b1;
    order_ref_i <= oref;
    is_sell_i <= sell;
    is_market_i <= mkt;
    limit_price_i <= px;
    order_qty_i <= qty;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    // accepted at this edge
    book_order(oref, sell, mkt, px, qty);
    start_i <= 1'b0;
    // fresh ref for the next caller
    next_ref = next_ref + 32'd1;
    // block is busy for this cycle anyway
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (expected_trades.size() != 0) @(posedge clk_i);
  endtask

  // monitor: every strobed result is compared with the oldest expectation
  always @(posedge clk_i) begin
    trade_t e;
    if (rst_ni && valid_o) begin
      if (expected_trades.size() == 0) begin
        $display("%0t: unexpected result kind %0d taker %h", $time, kind_o, taker_ref_o);
        errors++;
      end else begin
        e = expected_trades.pop_front();
        if (kind_o != e.kind) begin
          $display("%0t: kind exp %0d got %0d", $time, e.kind, kind_o); errors++;
        end
        if (taker_ref_o != e.taker) begin
          $display("%0t: taker exp %h got %h", $time, e.taker, taker_ref_o); errors++;
        end
        if (maker_ref_o != e.maker) begin
          $display("%0t: maker exp %h got %h", $time, e.maker, maker_ref_o); errors++;
        end
        if (trade_qty_o != e.qty) begin
          $display("%0t: qty exp %h got %h", $time, e.qty, trade_qty_o); errors++;
        end
        if (trade_price_o != e.price) begin
          $display("%0t: price exp %h got %h", $time, e.price, trade_price_o); errors++;
        end
        if (last_o != e.last) begin
          $display("%0t: last exp %b got %b", $time, e.last, last_o); errors++;
        end
      end
    end
  end

  // watchdog: cycles in which nothing is accepted and no result is strobed
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Directed: extremes of every field, zero quantity, empty book, market orders.
  task automatic test_edges();
    send_order(32'hFFFF_FFFF, 1'b0, 1'b1, 32'd5, 32'd10);      // market into empty book
    send_order(32'd0, 1'b1, 1'b0, 32'd100, 32'd0);             // zero quantity
    send_order(next_ref, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_order(next_ref, 1'b1, 1'b0, 32'd0, 32'd7);
    send_order(next_ref, 1'b0, 1'b0, 32'd0, 32'd3);            // buy at 0 crosses ask at 0
    send_order(next_ref, 1'b0, 1'b0, 32'd0, 32'd9);            // rests after partial
    send_order(next_ref, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // sweeps asks, fully filled
    send_order(next_ref, 1'b1, 1'b1, 32'd0, 32'd4);            // market sell into bids
    send_order(next_ref, 1'b1, 1'b1, 32'd0, 32'd100);
    send_order(next_ref, 1'b0, 1'b0, 32'hAAAA_5555, 32'h5555_AAAA);
    send_order(next_ref, 1'b1, 1'b0, 32'hAAAA_5556, 32'd1);    // no cross, rests
    send_order(next_ref, 1'b1, 1'b0, 32'h1, 32'h5555_AAAA);    // hits the bid fully
  endtask

  // Fill the bid book to depth, get two rejections, then clear it in one sweep.
  task automatic test_full_book();
    int i;
    wait_drained();
    for (i = 0; i < DEPTH + 2; i++)
      send_order(next_ref, 1'b0, 1'b0, 32'd1000 + $urandom_range(3), 32'd1 + $urandom_range(4));
    send_order(next_ref, 1'b1, 1'b0, 32'd0, 32'hFFFF_FFFF);   // sweep and rest the rest
    send_order(next_ref, 1'b0, 1'b1, 32'd0, 32'hFFFF_FFFF);   // clear the ask
    wait_drained();                                            // sender holds off
  endtask

  task automatic test_random(input int n);
    int i;
    logic sell;
    logic [31:0] px, qty;
    for (i = 0; i < n; i++) begin
      sell = 1'($urandom_range(1));
      // mostly a narrow price band so books cross; sometimes full-range noise
      if ($urandom_range(9) == 0) px = $urandom();
      else px = 32'd5000 + $urandom_range(20);
      case ($urandom_range(9))
        0: qty = 32'd0;
        1: qty = $urandom();
        default: qty = 32'd1 + $urandom_range(50);
      endcase
      send_order($urandom(), sell, $urandom_range(9) == 0, px, qty);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    gap_pct = 8;
    test_edges();
    test_full_book();
    test_random(80);
    gap_pct = 78;
    test_random(80);
    gap_pct = 0;
    test_random(80);
    wait_drained();
    repeat (200) @(posedge clk_i);
    if (errors == 0 && expected_trades.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

@@ sim.f @@
rtl/lome_pkg.sv
rtl/limit_order_matching_engine.sv
rtl/lome_checker.sv
verif/tb.sv
